@@ design/sgdwu_pkg.sv @@
// ============================================================================
// sgdwu_pkg
// Shared types and constants of the SGD weight update engine: item actions,
// register indexes, field widths and the controller/datapath signal groups.
// ============================================================================
package sgdwu_pkg;

    localparam int MAX_ROWS_DEF  = 256;
    localparam int MAX_COLS_DEF  = 1024;
    localparam int FRAC_BITS_DEF = 24;
    localparam int RATE_BITS     = 24;

    localparam int ACTION_W = 3;
    localparam int ROW_W    = 8;
    localparam int COL_W    = 10;
    localparam int DATA_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int ROWS_USE_W = 9;
    localparam int COLS_USE_W = 11;

    localparam logic [RATE_BITS-1:0]  LEARN_RATE_RST  = 24'd1677722;
    localparam logic [RATE_BITS-1:0]  DECAY_RATE_RST  = 24'd17;
    localparam logic [ROWS_USE_W-1:0] ROWS_IN_USE_RST = 9'd256;
    localparam logic [COLS_USE_W-1:0] COLS_IN_USE_RST = 11'd1024;

    localparam logic signed [DATA_W-1:0] W_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] W_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_ACT     = 3'd0,
        ACT_LOAD_ERR     = 3'd1,
        ACT_WRITE_WEIGHT = 3'd2,
        ACT_READ_WEIGHT  = 3'd3,
        ACT_UPDATE_COL   = 3'd4,
        ACT_UPDATE_ROW   = 3'd5
    } action_t;

    typedef struct packed {
        logic item_ready;
        logic act_wr;
        logic err_wr;
        logic wt_wr;
        logic wt_rd;
        logic cnt_clear;
        logic sweep_issue;
        logic res_load;
    } sgdwu_cmd_t;

    typedef struct packed {
        logic    item_valid;
        action_t action;
        logic    item_ok;
        logic    sweep_empty;
        logic    sweep_last;
        logic    pipe_busy;
        logic    out_free;
    } sgdwu_stat_t;

endpackage

@@ design/sgdwu_item_if.sv @@
// ============================================================================
// sgdwu_item_if
// Request channel of the engine: one action with its indexes and data.
// ============================================================================
interface sgdwu_item_if
    import sgdwu_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic [ROW_W-1:0]         row_index;
    logic [COL_W-1:0]         col_index;
    logic signed [DATA_W-1:0] data_value;
    logic                     regularize;

    modport source (output valid, action, row_index, col_index, data_value, regularize,
                    input ready);
    modport sink   (input valid, action, row_index, col_index, data_value, regularize,
                    output ready);
endinterface

@@ design/sgdwu_result_if.sv @@
// ============================================================================
// sgdwu_result_if
// Result channel of the engine: read-back weight and status of one request.
// ============================================================================
interface sgdwu_result_if
    import sgdwu_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic                     status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

@@ design/sgdwu_cfg_if.sv @@
// ============================================================================
// sgdwu_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface sgdwu_cfg_if
    import sgdwu_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/sgdwu_ctrl.sv @@
// ============================================================================
// sgdwu_ctrl
// Controller of the engine: takes a request, runs the single access or the
// update sweep in the datapath, waits for the pipeline to drain and loads
// the result register.
// ============================================================================
module sgdwu_ctrl
    import sgdwu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sgdwu_stat_t stat,
    output sgdwu_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_READ   = 6'b000100,
        ST_SWEEP  = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.item_ready = 1'b1;
                if (stat.item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESULT;
                case (stat.action)
                    ACT_LOAD_ACT:     cmd.act_wr = stat.item_ok;
                    ACT_LOAD_ERR:     cmd.err_wr = stat.item_ok;
                    ACT_WRITE_WEIGHT: cmd.wt_wr  = stat.item_ok;
                    ACT_READ_WEIGHT:
                    begin
                        if (stat.item_ok)
                        begin
                            cmd.wt_rd  = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    ACT_UPDATE_COL, ACT_UPDATE_ROW:
                    begin
                        if (stat.item_ok && !stat.sweep_empty)
                        begin
                            cmd.cnt_clear = 1'b1;
                            state_next    = ST_SWEEP;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_READ:
            begin
                state_next = ST_RESULT;
            end
            ST_SWEEP:
            begin
                cmd.sweep_issue = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/sgdwu_datapath.sv @@
// ============================================================================
// sgdwu_datapath
// Datapath of the engine: configuration registers, request registers, the
// weight, activation and error memories, the sweep counter, the four-stage
// update pipeline and the result register.
// ============================================================================
module sgdwu_datapath
    import sgdwu_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    sgdwu_item_if.sink      items,
    sgdwu_result_if.source  results,
    sgdwu_cfg_if.sink       cfg,
    input  sgdwu_cmd_t      cmd,
    output sgdwu_stat_t     stat
);

    localparam int RAW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CAW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int WAW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
    localparam int RIW  = (RAW > ROW_W) ? RAW : ROW_W;
    localparam int CIW  = (CAW > COL_W) ? CAW : COL_W;
    localparam int RLW  = ($clog2(MAX_ROWS + 1) > ROWS_USE_W) ? $clog2(MAX_ROWS + 1) : ROWS_USE_W;
    localparam int CLW  = ($clog2(MAX_COLS + 1) > COLS_USE_W) ? $clog2(MAX_COLS + 1) : COLS_USE_W;
    localparam int KW   = (RLW > CLW) ? RLW : CLW;
    localparam int PW   = 2 * DATA_W;
    localparam int HIW  = PW - FRAC_BITS - RATE_BITS;
    localparam int HLW  = HIW + RATE_BITS + 1;
    localparam int TW   = HLW + 1;
    localparam int DPW  = DATA_W + RATE_BITS + 1;
    localparam int DW   = DPW - RATE_BITS;
    localparam int NVW  = HIW + 28;

    // Configuration registers.
    logic [RATE_BITS-1:0]  learn_rate_reg;
    logic [RATE_BITS-1:0]  decay_rate_reg;
    logic [ROWS_USE_W-1:0] rows_in_use_reg;
    logic [COLS_USE_W-1:0] cols_in_use_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg  <= LEARN_RATE_RST;
            decay_rate_reg  <= DECAY_RATE_RST;
            rows_in_use_reg <= ROWS_IN_USE_RST;
            cols_in_use_reg <= COLS_IN_USE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_LEARN_RATE:  learn_rate_reg  <= cfg.data;
                CFG_DECAY_RATE:  decay_rate_reg  <= cfg.data;
                CFG_ROWS_IN_USE: rows_in_use_reg <= cfg.data[ROWS_USE_W-1:0];
                CFG_COLS_IN_USE: cols_in_use_reg <= cfg.data[COLS_USE_W-1:0];
                default:         learn_rate_reg  <= learn_rate_reg;
            endcase
        end
    end

    // Request registers.
    action_t                  action_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [COL_W-1:0]         col_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic                     regularize_reg;

    assign items.ready = cmd.item_ready;

    always_ff @(posedge clk)
    begin
        if (items.valid && cmd.item_ready)
        begin
            action_reg     <= action_t'(items.action);
            row_reg        <= items.row_index;
            col_reg        <= items.col_index;
            data_reg       <= items.data_value;
            regularize_reg <= items.regularize;
        end
    end

    // Index checks and sweep length.
    logic [RLW-1:0] row_limit;
    logic [CLW-1:0] col_limit;
    logic           row_ok;
    logic           col_ok;
    logic           item_ok;
    logic [RIW-1:0] row_wide;
    logic [CIW-1:0] col_wide;
    logic [RAW-1:0] row_addr;
    logic [CAW-1:0] col_addr;
    logic [KW-1:0]  sweep_len;
    logic [KW-1:0]  cnt_reg;
    logic           col_sweep;

    assign row_limit = (RLW'(rows_in_use_reg) < RLW'(MAX_ROWS)) ?
                       RLW'(rows_in_use_reg) : RLW'(MAX_ROWS);
    assign col_limit = (CLW'(cols_in_use_reg) < CLW'(MAX_COLS)) ?
                       CLW'(cols_in_use_reg) : CLW'(MAX_COLS);
    assign row_ok    = RLW'(row_reg) < row_limit;
    assign col_ok    = CLW'(col_reg) < col_limit;
    assign row_wide  = RIW'(row_reg);
    assign col_wide  = CIW'(col_reg);
    assign row_addr  = row_wide[RAW-1:0];
    assign col_addr  = col_wide[CAW-1:0];
    assign col_sweep = (action_reg == ACT_UPDATE_COL);
    assign sweep_len = col_sweep ? KW'(row_limit) : KW'(col_limit);

    always_comb
    begin
        case (action_reg)
            ACT_LOAD_ACT:     item_ok = row_ok;
            ACT_LOAD_ERR:     item_ok = col_ok;
            ACT_WRITE_WEIGHT: item_ok = row_ok && col_ok;
            ACT_READ_WEIGHT:  item_ok = row_ok && col_ok;
            ACT_UPDATE_COL:   item_ok = col_ok;
            ACT_UPDATE_ROW:   item_ok = row_ok;
            default:          item_ok = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cnt_clear)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.sweep_issue)
        begin
            cnt_reg <= cnt_reg + KW'(1);
        end
    end

    // Memory addressing.
    logic [RAW-1:0] rd_row;
    logic [CAW-1:0] rd_col;
    logic [WAW-1:0] item_waddr;
    logic [WAW-1:0] sweep_waddr;
    logic [WAW-1:0] wt_raddr;
    logic           wt_re;

    assign rd_row      = col_sweep ? cnt_reg[RAW-1:0] : row_addr;
    assign rd_col      = col_sweep ? col_addr : cnt_reg[CAW-1:0];
    assign item_waddr  = WAW'(row_addr) * WAW'(MAX_COLS) + WAW'(col_addr);
    assign sweep_waddr = WAW'(rd_row) * WAW'(MAX_COLS) + WAW'(rd_col);
    assign wt_raddr    = cmd.sweep_issue ? sweep_waddr : item_waddr;
    assign wt_re       = cmd.sweep_issue || cmd.wt_rd;

    logic signed [DATA_W-1:0] wt_mem  [MAX_ROWS * MAX_COLS];
    logic signed [DATA_W-1:0] act_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] err_mem [MAX_COLS];

    logic signed [DATA_W-1:0] wt_rd_reg;
    logic signed [DATA_W-1:0] act_rd_reg;
    logic signed [DATA_W-1:0] err_rd_reg;

    // Pipeline registers.
    logic                     s1_valid_reg;
    logic [WAW-1:0]           s1_addr_reg;
    logic                     s2_valid_reg;
    logic [WAW-1:0]           s2_addr_reg;
    logic signed [PW-1:0]     s2_prod_reg;
    logic signed [DW-1:0]     s2_dec_reg;
    logic signed [DATA_W-1:0] s2_w_reg;
    logic                     s3_valid_reg;
    logic [WAW-1:0]           s3_addr_reg;
    logic signed [HLW-1:0]    s3_hl_reg;
    logic [RATE_BITS-1:0]     s3_ll_reg;
    logic signed [DW-1:0]     s3_dec_reg;
    logic signed [DATA_W-1:0] s3_w_reg;
    logic                     s4_valid_reg;
    logic [WAW-1:0]           s4_addr_reg;
    logic signed [TW-1:0]     s4_term_reg;
    logic signed [DW-1:0]     s4_dec_reg;
    logic signed [DATA_W-1:0] s4_w_reg;

    logic [WAW-1:0]           wt_waddr;
    logic signed [DATA_W-1:0] wt_wdata;
    logic                     wt_we;
    logic signed [DATA_W-1:0] sat_value;

    assign wt_we    = s4_valid_reg || cmd.wt_wr;
    assign wt_waddr = s4_valid_reg ? s4_addr_reg : item_waddr;
    assign wt_wdata = s4_valid_reg ? sat_value : data_reg;

    always_ff @(posedge clk)
    begin
        if (wt_we)
        begin
            wt_mem[wt_waddr] <= wt_wdata;
        end
        if (wt_re)
        begin
            wt_rd_reg <= wt_mem[wt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.act_wr)
        begin
            act_mem[row_addr] <= data_reg;
        end
        if (cmd.sweep_issue)
        begin
            act_rd_reg <= act_mem[rd_row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.err_wr)
        begin
            err_mem[col_addr] <= data_reg;
        end
        if (cmd.sweep_issue)
        begin
            err_rd_reg <= err_mem[rd_col];
        end
    end

    // Stage arithmetic.
    logic signed [PW-1:0]        prod_next;
    logic signed [DPW-1:0]       dec_prod;
    logic signed [HIW-1:0]       p_hi;
    logic [RATE_BITS-1:0]        p_lo;
    logic signed [HLW-1:0]       hl_next;
    logic [2*RATE_BITS-1:0]      ll_prod;
    logic signed [TW-1:0]        term_next;
    logic signed [NVW-1:0]       dec_sel;
    logic signed [NVW-1:0]       new_value;
    logic                        fits;

    assign prod_next = err_rd_reg * act_rd_reg;
    assign dec_prod  = wt_rd_reg * $signed({1'b0, decay_rate_reg});
    assign p_hi      = s2_prod_reg[PW-1:FRAC_BITS+RATE_BITS];
    assign p_lo      = s2_prod_reg[FRAC_BITS+RATE_BITS-1:FRAC_BITS];
    assign hl_next   = p_hi * $signed({1'b0, learn_rate_reg});
    assign ll_prod   = p_lo * learn_rate_reg;
    assign term_next = TW'(s3_hl_reg) + TW'($signed({1'b0, s3_ll_reg}));
    assign dec_sel   = regularize_reg ? NVW'(s4_dec_reg) : NVW'(1'sb0);
    assign new_value = NVW'(s4_w_reg) + NVW'(s4_term_reg) - dec_sel;
    assign fits      = (&new_value[NVW-1:DATA_W-1]) || !(|new_value[NVW-1:DATA_W-1]);
    assign sat_value = fits ? new_value[DATA_W-1:0] : (new_value[NVW-1] ? W_MIN : W_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.sweep_issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= sweep_waddr;
        s2_addr_reg <= s1_addr_reg;
        s2_prod_reg <= prod_next;
        s2_dec_reg  <= dec_prod[DPW-1:RATE_BITS];
        s2_w_reg    <= wt_rd_reg;
        s3_addr_reg <= s2_addr_reg;
        s3_hl_reg   <= hl_next;
        s3_ll_reg   <= ll_prod[2*RATE_BITS-1:RATE_BITS];
        s3_dec_reg  <= s2_dec_reg;
        s3_w_reg    <= s2_w_reg;
        s4_addr_reg <= s3_addr_reg;
        s4_term_reg <= term_next;
        s4_dec_reg  <= s3_dec_reg;
        s4_w_reg    <= s3_w_reg;
    end

    // Result register.
    logic                     res_valid_reg;
    logic signed [DATA_W-1:0] res_value_reg;
    logic                     res_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_value_reg  <= (action_reg == ACT_READ_WEIGHT && item_ok) ? wt_rd_reg : '0;
            res_status_reg <= !item_ok;
        end
    end

    assign results.valid      = res_valid_reg;
    assign results.read_value = res_value_reg;
    assign results.status     = res_status_reg;

    assign stat.item_valid  = items.valid;
    assign stat.action      = action_reg;
    assign stat.item_ok     = item_ok;
    assign stat.sweep_empty = (sweep_len == '0);
    assign stat.sweep_last  = (cnt_reg == sweep_len - KW'(1));
    assign stat.pipe_busy   = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;
    assign stat.out_free    = !res_valid_reg || results.ready;

endmodule

@@ design/sgd_weight_update_engine_core.sv @@
// ============================================================================
// sgd_weight_update_engine_core
// SGD weight update engine with optional L2 decay, signed fixed point.
//
// Requests arrive on the items channel and each gives exactly one response
// on the results channel; registers are written on the cfg channel, which
// is always ready and must only be used while the engine is idle.
// An update sweep of N weights reads and writes back one weight per cycle
// through a four-stage multiply pipeline, using the separate read and write
// ports of the weight memory; the pipeline is drained before the response.
// One request is processed at a time.
// Reset restores the configuration defaults; the weight, activation and
// error memories are not cleared and hold nothing valid until written.
// The response waits in an output register while the receiver stalls; the
// next request is accepted meanwhile, and its response is held back until
// that register has been taken.
// ============================================================================
module sgd_weight_update_engine_core
    import sgdwu_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    sgdwu_item_if.sink      items,
    sgdwu_result_if.source  results,
    sgdwu_cfg_if.sink       cfg
);

    sgdwu_cmd_t  cmd;
    sgdwu_stat_t stat;

    sgdwu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    sgdwu_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the SGD weight update engine. A scoreboard keeps
// its own copy of the registers and of the weight, activation and error
// memories, predicts the response to every accepted request and compares
// each response field by field. A short directed sequence is followed by
// random phases at several register settings, from an empty matrix to the
// full and oversized sizes, with random idling on both channels.
// ============================================================================
module testbench;
    import sgdwu_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam int ROW_FIELD_MAX = (1 << ROW_W) - 1;
    localparam int COL_FIELD_MAX = (1 << COL_W) - 1;
    localparam logic [RATE_BITS-1:0] RATE_FULL = 24'hFF_FFFF;

    typedef logic signed [95:0] wide_t;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic signed [DATA_W-1:0] data;
        logic                     regularize;
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     status;
    } response_t;

    class sgd_update_scoreboard;
        logic [RATE_BITS-1:0]     learn_rate;
        logic [RATE_BITS-1:0]     decay_rate;
        logic [ROWS_USE_W-1:0]    rows_in_use;
        logic [COLS_USE_W-1:0]    cols_in_use;
        logic signed [DATA_W-1:0] weight_mem [MAX_ROWS_DEF*MAX_COLS_DEF];
        logic signed [DATA_W-1:0] act_mem [MAX_ROWS_DEF];
        logic signed [DATA_W-1:0] err_mem [MAX_COLS_DEF];
        bit                       weight_seen [MAX_ROWS_DEF*MAX_COLS_DEF];
        bit                       act_seen [MAX_ROWS_DEF];
        bit                       err_seen [MAX_COLS_DEF];
        response_t                pending_responses [$];
        int                       failures;

        function new();
            learn_rate  = LEARN_RATE_RST;
            decay_rate  = DECAY_RATE_RST;
            rows_in_use = ROWS_IN_USE_RST;
            cols_in_use = COLS_IN_USE_RST;
            failures    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_LEARN_RATE:  learn_rate  = data;
                CFG_DECAY_RATE:  decay_rate  = data;
                CFG_ROWS_IN_USE: rows_in_use = data[ROWS_USE_W-1:0];
                CFG_COLS_IN_USE: cols_in_use = data[COLS_USE_W-1:0];
                default: ;
            endcase
        endfunction

        function int row_limit();
            return (rows_in_use < MAX_ROWS_DEF) ? int'(rows_in_use) : MAX_ROWS_DEF;
        endfunction

        function int col_limit();
            return (cols_in_use < MAX_COLS_DEF) ? int'(cols_in_use) : MAX_COLS_DEF;
        endfunction

        function int cell_addr(int r, int c);
            return r * MAX_COLS_DEF + c;
        endfunction

        // True when the request would touch a memory entry never written.
        function bit reads_unwritten(request_t q);
            int r;
            int c;
            int k;
            bit hit;
            r   = q.row;
            c   = q.col;
            hit = 1'b0;
            case (q.action)
                ACT_READ_WEIGHT:
                    hit = r < row_limit() && c < col_limit() && !weight_seen[cell_addr(r, c)];
                ACT_UPDATE_COL:
                    if (c < col_limit())
                    begin
                        for (k = 0; k < row_limit(); k++)
                            hit |= !act_seen[k] || !err_seen[c] || !weight_seen[cell_addr(k, c)];
                    end
                ACT_UPDATE_ROW:
                    if (r < row_limit())
                    begin
                        for (k = 0; k < col_limit(); k++)
                            hit |= !act_seen[r] || !err_seen[k] || !weight_seen[cell_addr(r, k)];
                    end
                default: ;
            endcase
            return hit;
        endfunction

        function void sweep_cell(int r, int c, bit reg_on);
            wide_t w;
            wide_t p;
            wide_t nv;
            w  = wide_t'(weight_mem[cell_addr(r, c)]);
            p  = (wide_t'(err_mem[c]) * wide_t'(act_mem[r])) >>> FRAC_BITS_DEF;
            nv = w + ((p * wide_t'(learn_rate)) >>> RATE_BITS);
            if (reg_on)
                nv = nv - ((w * wide_t'(decay_rate)) >>> RATE_BITS);
            if (nv > wide_t'(W_MAX))
                nv = wide_t'(W_MAX);
            else if (nv < wide_t'(W_MIN))
                nv = wide_t'(W_MIN);
            weight_mem[cell_addr(r, c)] = nv[DATA_W-1:0];
        endfunction

        function void note_request(request_t q);
            response_t resp;
            int r;
            int c;
            int k;
            bit row_ok;
            bit col_ok;
            r           = q.row;
            c           = q.col;
            row_ok      = r < row_limit();
            col_ok      = c < col_limit();
            resp.value  = '0;
            resp.status = 1'b0;
            case (q.action)
                ACT_LOAD_ACT:
                    if (row_ok)
                    begin
                        act_mem[r]  = q.data;
                        act_seen[r] = 1'b1;
                    end
                    else
                        resp.status = 1'b1;
                ACT_LOAD_ERR:
                    if (col_ok)
                    begin
                        err_mem[c]  = q.data;
                        err_seen[c] = 1'b1;
                    end
                    else
                        resp.status = 1'b1;
                ACT_WRITE_WEIGHT:
                    if (row_ok && col_ok)
                    begin
                        weight_mem[cell_addr(r, c)]  = q.data;
                        weight_seen[cell_addr(r, c)] = 1'b1;
                    end
                    else
                        resp.status = 1'b1;
                ACT_READ_WEIGHT:
                    if (row_ok && col_ok)
                        resp.value = weight_mem[cell_addr(r, c)];
                    else
                        resp.status = 1'b1;
                ACT_UPDATE_COL:
                    if (col_ok)
                    begin
                        for (k = 0; k < row_limit(); k++)
                            sweep_cell(k, c, q.regularize);
                    end
                    else
                        resp.status = 1'b1;
                ACT_UPDATE_ROW:
                    if (row_ok)
                    begin
                        for (k = 0; k < col_limit(); k++)
                            sweep_cell(r, k, q.regularize);
                    end
                    else
                        resp.status = 1'b1;
                default: ;
            endcase
            pending_responses.push_back(resp);
        endfunction

        function void check_response(logic signed [DATA_W-1:0] value, logic status);
            response_t want;
            if (pending_responses.size() == 0)
            begin
                $error("unexpected response: read_value %0d, status %0d", value, status);
                failures++;
                return;
            end
            want = pending_responses.pop_front();
            if (value !== want.value)
            begin
                $error("read_value mismatch: expected %0d, actual %0d", want.value, value);
                failures++;
            end
            if (status !== want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_gap_odds;
    int   ready_stall_odds;

    sgd_update_scoreboard engine_model;

    sgdwu_item_if   item_ch ();
    sgdwu_result_if result_ch ();
    sgdwu_cfg_if    cfg_ch ();

    sgd_weight_update_engine_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && ready_stall_odds > 0 && $urandom_range(1, ready_stall_odds) == 1)
                stall_left = $urandom_range(1, 18);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            engine_model.check_response(result_ch.read_value, result_ch.status);
    end

    function automatic int pick_index(int lim, int field_max);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return field_max;
            2:       return $urandom_range(0, field_max);
            default: return (lim > 0) ? $urandom_range(0, (lim > field_max) ? field_max : lim - 1)
                                      : $urandom_range(0, field_max);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_data();
        logic signed [DATA_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 5))
            0:       return W_MAX;
            1:       return W_MIN;
            2, 3:    return v >>> 6;
            default: return v;
        endcase
    endfunction

    function automatic logic [RATE_BITS-1:0] pick_rate();
        return RATE_BITS'($urandom_range(0, RATE_FULL));
    endfunction

    function automatic request_t random_request();
        request_t q;
        int tries;
        for (tries = 0; tries < 40; tries++)
        begin
            if ($urandom_range(0, 19) == 0)
                q.action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
            else
                q.action = ACTION_W'($urandom_range(ACT_LOAD_ACT, ACT_UPDATE_ROW));
            q.row        = ROW_W'(pick_index(engine_model.row_limit(), ROW_FIELD_MAX));
            q.col        = COL_W'(pick_index(engine_model.col_limit(), COL_FIELD_MAX));
            q.data       = pick_data();
            q.regularize = 1'($urandom_range(0, 1));
            if (!engine_model.reads_unwritten(q))
                return q;
        end
        q.action = ACT_LOAD_ACT;
        return q;
    endfunction

    task automatic issue(request_t q);
        if (send_gap_odds > 0 && $urandom_range(1, send_gap_odds) == 1)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.action     <= q.action;
        item_ch.row_index  <= q.row;
        item_ch.col_index  <= q.col;
        item_ch.data_value <= q.data;
        item_ch.regularize <= q.regularize;
        do
            @(posedge clk);
        while (!item_ch.ready);
        engine_model.note_request(q);
    endtask

    task automatic directed(logic [ACTION_W-1:0] action, int row, int col,
                            logic signed [DATA_W-1:0] data, bit regularize);
        request_t q;
        q.action     = action;
        q.row        = ROW_W'(row);
        q.col        = COL_W'(col);
        q.data       = data;
        q.regularize = regularize;
        issue(q);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (engine_model.pending_responses.size() != 0);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        engine_model.write_register(index, data);
    endtask

    task automatic configure(int rows, int cols, logic [RATE_BITS-1:0] lr,
                             logic [RATE_BITS-1:0] dr);
        drain();
        write_register(CFG_LEARN_RATE, lr);
        write_register(CFG_DECAY_RATE, dr);
        write_register(CFG_ROWS_IN_USE, CFG_DATA_W'(rows));
        write_register(CFG_COLS_IN_USE, CFG_DATA_W'(cols));
        cfg_ch.valid <= 1'b0;
    endtask

    // Fills every entry that a sweep in the current region may read; with
    // first_col_only set, only the entries that a sweep of column 0 reads.
    task automatic prime(bit first_col_only);
        int r;
        int c;
        int c_end;
        c_end = engine_model.col_limit();
        if (first_col_only && c_end > 1)
            c_end = 1;
        for (r = 0; r < engine_model.row_limit(); r++)
            if (!engine_model.act_seen[r])
                directed(ACT_LOAD_ACT, r, 0, pick_data(), 1'b0);
        for (c = 0; c < c_end; c++)
            if (!engine_model.err_seen[c])
                directed(ACT_LOAD_ERR, 0, c, pick_data(), 1'b0);
        for (r = 0; r < engine_model.row_limit(); r++)
            for (c = 0; c < c_end; c++)
                if (!engine_model.weight_seen[engine_model.cell_addr(r, c)])
                    directed(ACT_WRITE_WEIGHT, r, c, pick_data(), 1'b0);
    endtask

    task automatic run_phase(int rows, int cols, logic [RATE_BITS-1:0] lr,
                             logic [RATE_BITS-1:0] dr, int count, int gap_odds,
                             int stall_odds, bit first_col_only);
        int i;
        configure(rows, cols, lr, dr);
        send_gap_odds    = gap_odds;
        ready_stall_odds = stall_odds;
        prime(first_col_only);
        for (i = 0; i < count; i++)
        begin
            if (i == count / 2 || $urandom_range(0, 199) == 0)
                drain();
            issue(random_request());
        end
    endtask

    initial
    begin
        engine_model          = new();
        rst_n                 = 1'b0;
        send_gap_odds         = 4;
        ready_stall_odds      = 4;
        item_ch.valid         = 1'b0;
        item_ch.action        = ACT_LOAD_ACT;
        item_ch.row_index     = '0;
        item_ch.col_index     = '0;
        item_ch.data_value    = '0;
        item_ch.regularize    = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_LEARN_RATE;
        cfg_ch.data           = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        configure(2, 3, RATE_FULL, RATE_FULL);
        directed(ACT_LOAD_ACT, 0, 0, W_MAX, 1'b0);
        directed(ACT_LOAD_ACT, 1, 0, W_MIN, 1'b1);
        directed(ACT_LOAD_ERR, 0, 0, W_MAX, 1'b0);
        directed(ACT_LOAD_ERR, 0, 1, W_MIN, 1'b0);
        directed(ACT_LOAD_ERR, 0, 2, 32'sh0100_0000, 1'b0);
        directed(ACT_WRITE_WEIGHT, 0, 0, W_MAX, 1'b0);
        directed(ACT_WRITE_WEIGHT, 0, 1, W_MIN, 1'b0);
        directed(ACT_WRITE_WEIGHT, 0, 2, 32'sh0, 1'b0);
        directed(ACT_WRITE_WEIGHT, 1, 0, W_MIN, 1'b0);
        directed(ACT_WRITE_WEIGHT, 1, 1, -32'sd1, 1'b0);
        directed(ACT_WRITE_WEIGHT, 1, 2, 32'sh0100_0000, 1'b0);
        directed(ACT_READ_WEIGHT, 1, 2, 32'sh0, 1'b0);
        directed(ACT_UPDATE_COL, 0, 0, 32'sh0, 1'b1);
        directed(ACT_UPDATE_ROW, 1, 0, 32'sh0, 1'b0);
        directed(ACT_UPDATE_ROW, 0, 0, 32'sh0, 1'b1);
        directed(ACT_UPDATE_COL, 0, 2, 32'sh0, 1'b0);
        directed(ACT_READ_WEIGHT, 0, 0, 32'sh0, 1'b0);
        directed(ACT_READ_WEIGHT, 1, 1, 32'sh0, 1'b0);
        directed(ACT_LOAD_ACT, ROW_FIELD_MAX, 0, -32'sd1, 1'b0);
        directed(ACT_LOAD_ERR, 0, COL_FIELD_MAX, -32'sd1, 1'b0);
        directed(ACT_WRITE_WEIGHT, 0, 3, W_MAX, 1'b0);
        directed(ACT_READ_WEIGHT, 2, 0, 32'sh0, 1'b0);
        directed(ACT_UPDATE_COL, 0, 3, 32'sh0, 1'b1);
        directed(ACT_UPDATE_ROW, ROW_FIELD_MAX, 0, 32'sh0, 1'b1);
        directed(ACT_SPARE_LO, 0, 0, 32'sh0, 1'b0);
        directed(ACT_SPARE_HI, ROW_FIELD_MAX, COL_FIELD_MAX, -32'sd1, 1'b1);

        run_phase(3, 5, pick_rate(), pick_rate(), 100, 5, 5, 1'b0);
        run_phase(8, 8, '0, '0, 100, 0, 3, 1'b0);
        run_phase(16, 4, RATE_FULL, RATE_FULL, 80, 3, 0, 1'b0);
        run_phase(0, 7, pick_rate(), pick_rate(), 30, 4, 4, 1'b0);
        run_phase(9, 0, pick_rate(), pick_rate(), 30, 4, 4, 1'b0);
        run_phase(1, 1, pick_rate(), pick_rate(), 40, 6, 6, 1'b0);
        run_phase(MAX_ROWS_DEF, MAX_COLS_DEF, LEARN_RATE_RST, DECAY_RATE_RST,
                  30, 10, 8, 1'b1);
        run_phase((1 << ROWS_USE_W) - 1, (1 << COLS_USE_W) - 1,
                  pick_rate(), pick_rate(), 30, 5, 5, 1'b1);
        run_phase(4, 6, pick_rate(), pick_rate(), 120, 0, 0, 1'b0);

        drain();
        repeat (20) @(posedge clk);
        if (engine_model.failures == 0 && engine_model.pending_responses.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ sim.f @@
design/sgdwu_pkg.sv
design/sgdwu_item_if.sv
design/sgdwu_result_if.sv
design/sgdwu_cfg_if.sv
design/sgdwu_ctrl.sv
design/sgdwu_datapath.sv
design/sgd_weight_update_engine_core.sv
verif/testbench.sv
